### rtl/ftcp_pkg.sv
// Package for the finger track chunk parser: item types, phase codes and magic bytes.
`default_nettype none

package ftcp_pkg;

	// Input item: one raw byte of the stream
	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
	} in_item_t;

	// Result item: one per input byte
	typedef struct packed {
		logic        event_valid;
		logic [7:0]  event_byte;
		logic [15:0] track_number;
		logic        is_checkpoint;
		logic        last_of_track;
		logic        file_done;
		logic [1:0]  status;
	} out_item_t;

	typedef enum logic [2:0] {
		PH_FILE_MAGIC,
		PH_TRACK_COUNT,
		PH_TRACK_MAGIC,
		PH_TRACK_LEN,
		PH_EVENTS,
		PH_DONE,
		PH_ERROR
	} phase_t;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_BAD_FILE  = 2'd1;
	localparam logic [1:0] STATUS_BAD_TRACK = 2'd2;

	localparam logic [7:0] CHECKPOINT_BYTE = 8'hC0;

	// Parser state
	typedef struct packed {
		phase_t      phase;
		logic [1:0]  byte_pos;
		logic        magic_bad;
		logic [15:0] declared_tracks;
		logic [15:0] current_track;
		logic [31:0] bytes_left;
		logic [1:0]  error_code;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		phase:           PH_FILE_MAGIC,
		byte_pos:        2'd0,
		magic_bad:       1'b0,
		declared_tracks: 16'd0,
		current_track:   16'd0,
		bytes_left:      32'd0,
		error_code:      STATUS_OK
	};

	// Expected magic byte: "MTfg" for the file header, "MTrk" for a track
	function automatic logic [7:0] magic_byte(input logic is_file, input logic [1:0] pos);
		logic [7:0] b;
		unique case (pos)
			2'd0: b = 8'h4D;
			2'd1: b = 8'h54;
			2'd2: b = is_file ? 8'h66 : 8'h72;
			2'd3: b = is_file ? 8'h67 : 8'h6B;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

### rtl/ftcp_parser.sv
// Parser state register with the next-state and result logic for one byte.
`default_nettype none

module ftcp_parser import ftcp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      advance,
	input  wire in_item_t  item,
	output out_item_t      result
);

	parse_state_t state_q;
	parse_state_t cur;
	parse_state_t nxt;
	logic [7:0]   b;
	logic         bad_n;
	logic [15:0]  track_inc;
	logic [31:0]  left_dec;

	assign b         = item.data_byte;
	assign track_inc = cur.current_track + 16'd1;
	assign left_dec  = cur.bytes_left - 32'd1;
	assign bad_n     = cur.magic_bad | (b != magic_byte(cur.phase == PH_FILE_MAGIC, cur.byte_pos));

	// Compute next state and result for the byte in the input stage
	always_comb begin
		cur = item.restart ? STATE_RESET : state_q;
		nxt = cur;
		result = '0;
		result.track_number = cur.current_track;
		unique case (cur.phase)
			PH_FILE_MAGIC, PH_TRACK_MAGIC: begin
				if (cur.byte_pos == 2'd3) begin
					nxt.byte_pos  = 2'd0;
					nxt.magic_bad = 1'b0;
					if (bad_n) begin
						nxt.error_code = (cur.phase == PH_FILE_MAGIC) ?
							STATUS_BAD_FILE : STATUS_BAD_TRACK;
						nxt.phase = PH_ERROR;
					end else begin
						nxt.phase = (cur.phase == PH_FILE_MAGIC) ? PH_TRACK_COUNT : PH_TRACK_LEN;
						nxt.bytes_left = 32'd0;
					end
				end else begin
					nxt.magic_bad = bad_n;
					nxt.byte_pos  = cur.byte_pos + 2'd1;
				end
			end
			PH_TRACK_COUNT: begin
				nxt.declared_tracks = {cur.declared_tracks[7:0], b};
				if (cur.byte_pos == 2'd1) begin
					nxt.byte_pos      = 2'd0;
					nxt.current_track = 16'd0;
					nxt.magic_bad     = 1'b0;
					nxt.phase = ({cur.declared_tracks[7:0], b} == 16'd0) ? PH_DONE : PH_TRACK_MAGIC;
				end else begin
					nxt.byte_pos = 2'd1;
				end
			end
			PH_TRACK_LEN: begin
				nxt.bytes_left = {cur.bytes_left[23:0], b};
				if (cur.byte_pos == 2'd3) begin
					nxt.byte_pos = 2'd0;
					if ({cur.bytes_left[23:0], b} == 32'd0) begin
						nxt.current_track = track_inc;
						nxt.magic_bad     = 1'b0;
						nxt.phase = (track_inc >= cur.declared_tracks) ? PH_DONE : PH_TRACK_MAGIC;
					end else begin
						nxt.phase = PH_EVENTS;
					end
				end else begin
					nxt.byte_pos = cur.byte_pos + 2'd1;
				end
			end
			PH_EVENTS: begin
				result.event_valid   = 1'b1;
				result.event_byte    = b;
				result.is_checkpoint = (b == CHECKPOINT_BYTE);
				result.last_of_track = (cur.bytes_left == 32'd1);
				nxt.bytes_left = left_dec;
				if (left_dec == 32'd0) begin
					nxt.current_track = track_inc;
					nxt.byte_pos      = 2'd0;
					nxt.magic_bad     = 1'b0;
					nxt.phase = (track_inc >= cur.declared_tracks) ? PH_DONE : PH_TRACK_MAGIC;
				end
			end
			default: begin
				// done or error: ignore the byte
			end
		endcase
		result.file_done = (nxt.phase == PH_DONE);
		result.status    = nxt.error_code;
	end

	// Commit state when the byte moves on to the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= nxt;
		end
	end

	a_error_has_code: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_ERROR) |-> (state_q.error_code != STATUS_OK))
		else $error("error phase without error code");

	a_code_only_in_error: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.error_code != STATUS_OK) |-> (state_q.phase == PH_ERROR))
		else $error("error code outside error phase");

	a_events_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_EVENTS) |-> (state_q.bytes_left != 32'd0))
		else $error("event phase with no bytes left");

	a_last_is_event: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && result.last_of_track) |-> result.event_valid)
		else $error("last-of-track on a non-event byte");

	a_count_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_TRACK_COUNT) |-> (state_q.byte_pos <= 2'd1))
		else $error("track count position out of range");

endmodule

`default_nettype wire

### rtl/finger_track_chunk_parser.sv
// Top level of the finger track chunk parser: input stage, parser and result stage.
// Each byte is registered in the input stage, then its result in the result stage.
// Throughput: one byte per cycle while results are taken; a full result stage
// holds the byte in the input stage. The parser state advances once per byte.
// The input and result registers let a byte enter while a result waits.
// Reset (arst_n low, asynchronous) empties both stages and returns the parser
// to the file magic phase with all counters and the error code cleared.
`default_nettype none

module finger_track_chunk_parser import ftcp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      byte_valid,
	output logic           byte_ready,
	input  wire in_item_t  byte_data,
	input  wire logic      result_ready,
	output logic           result_valid,
	output out_item_t      result_data
);

	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	out_item_t item_s2;
	out_item_t result_c;
	logic      advance;

	// Move the input stage on when the result stage is free or being drained
	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign byte_ready = !valid_s1 || advance;

	ftcp_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.item   (item_s1),
		.result (result_c)
	);

	// Stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (byte_ready) begin
				valid_s1 <= byte_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			item_s1 <= byte_data;
		end
		if (advance) begin
			item_s2 <= result_c;
		end
	end

	assign result_valid = valid_s2;
	assign result_data  = item_s2;

endmodule

`default_nettype wire

### tb/sv/tb.sv
// Testbench for the finger track chunk parser: directed and random byte streams, scoreboard check.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ftcp_pkg::*;

	localparam logic [31:0] FILE_TAG  = "MTfg";
	localparam logic [31:0] TRACK_TAG = "MTrk";
	localparam int          MAX_SHOWN = 10;

	logic      clk          = 1'b0;
	logic      arst_n;
	logic      byte_valid   = 1'b0;
	logic      byte_ready;
	in_item_t  byte_data    = '0;
	logic      result_ready = 1'b0;
	logic      result_valid;
	out_item_t result_data;

	// Parser shadow state
	phase_t      ph          = PH_FILE_MAGIC;
	logic [1:0]  field_pos   = '0;
	logic        magic_miss  = 1'b0;
	logic [15:0] track_total = '0;
	logic [15:0] track_idx   = '0;
	logic [31:0] len_left    = '0;
	logic [1:0]  err_status  = STATUS_OK;

	out_item_t   pending_results[$];
	bit          no_idle       = 1'b0;
	int          fail_count    = 0;
	int          bytes_sent    = 0;
	int          parsed_bytes  = 0;
	int          files_sent    = 0;
	int          events_seen   = 0;
	int          ckpts_seen    = 0;
	int          track_ends    = 0;
	int          done_results  = 0;
	int          error_results = 0;

	finger_track_chunk_parser uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.byte_data    (byte_data),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.result_data  (result_data)
	);

	always #2 clk = ~clk;

	// Return the shadow parser to its reset state
	task automatic clear_parser();
		ph          = PH_FILE_MAGIC;
		field_pos   = '0;
		magic_miss  = 1'b0;
		track_total = '0;
		track_idx   = '0;
		len_left    = '0;
		err_status  = STATUS_OK;
	endtask

	// Advance to the next track, or finish the file
	task automatic end_track();
		track_idx  = track_idx + 16'd1;
		field_pos  = '0;
		magic_miss = 1'b0;
		ph = (track_idx >= track_total) ? PH_DONE : PH_TRACK_MAGIC;
	endtask

	// Work out the result of one transferred byte and queue it
	task automatic parse_byte(input in_item_t it);
		out_item_t  r;
		logic [7:0] b;
		logic [7:0] want_b;
		logic       is_file;
		b = it.data_byte;
		r = '0;
		if (it.restart)
			clear_parser();
		r.track_number = track_idx;
		if (ph != PH_DONE && ph != PH_ERROR)
			parsed_bytes++;
		case (ph)
			PH_FILE_MAGIC, PH_TRACK_MAGIC: begin
				is_file = (ph == PH_FILE_MAGIC);
				want_b = is_file ? FILE_TAG[31 - 8 * int'(field_pos) -: 8]
						: TRACK_TAG[31 - 8 * int'(field_pos) -: 8];
				if (b != want_b)
					magic_miss = 1'b1;
				if (field_pos == 2'd3) begin
					field_pos = '0;
					if (magic_miss) begin
						err_status = is_file ? STATUS_BAD_FILE : STATUS_BAD_TRACK;
						ph = PH_ERROR;
					end else begin
						ph = is_file ? PH_TRACK_COUNT : PH_TRACK_LEN;
						len_left = '0;
					end
					magic_miss = 1'b0;
				end else begin
					field_pos = field_pos + 2'd1;
				end
			end
			PH_TRACK_COUNT: begin
				track_total = {track_total[7:0], b};
				if (field_pos == 2'd1) begin
					field_pos  = '0;
					track_idx  = '0;
					magic_miss = 1'b0;
					ph = (track_total == 16'd0) ? PH_DONE : PH_TRACK_MAGIC;
				end else begin
					field_pos = 2'd1;
				end
			end
			PH_TRACK_LEN: begin
				len_left = {len_left[23:0], b};
				if (field_pos == 2'd3) begin
					field_pos = '0;
					if (len_left == 32'd0)
						end_track();
					else
						ph = PH_EVENTS;
				end else begin
					field_pos = field_pos + 2'd1;
				end
			end
			PH_EVENTS: begin
				r.event_valid   = 1'b1;
				r.event_byte    = b;
				r.is_checkpoint = (b == CHECKPOINT_BYTE);
				r.last_of_track = (len_left == 32'd1);
				len_left = len_left - 32'd1;
				if (len_left == 32'd0)
					end_track();
			end
			default: ;
		endcase
		r.file_done = (ph == PH_DONE);
		r.status    = err_status;
		pending_results = {pending_results, r};
	endtask

	// Offer one byte, hold it until the transfer, then predict its result
	task automatic send_byte(input logic [7:0] b, input logic rs);
		in_item_t it;
		it.data_byte = b;
		it.restart   = rs;
		if (!no_idle && $urandom_range(0, 99) < 20) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data  <= it;
		do @(posedge clk); while (!byte_ready);
		parse_byte(it);
		bytes_sent++;
	endtask

	// Send the low n bytes of a word, most significant first
	task automatic send_word(input logic [31:0] w, input int n, input logic rs);
		int i;
		for (i = n - 1; i >= 0; i--)
			send_byte(w[8 * i +: 8], rs && (i == n - 1));
	endtask

	// Build one file, mostly well formed, sometimes damaged, and send it
	task automatic send_random_file(input bit clean);
		logic [7:0]  fb[$];
		int          tag_at[$];
		int          kind, ntracks, len, pick, keep, i, t;
		logic [15:0] cnt;
		logic [31:0] tlen;
		kind = (clean || $urandom_range(0, 99) >= 20) ? 0 : int'($urandom_range(1, 4));
		if (kind == 1) begin
			// raw noise
			repeat ($urandom_range(1, 12)) fb = {fb, 8'($urandom)};
		end else begin
			tag_at = {tag_at, fb.size()};
			for (i = 0; i < 4; i++)
				fb = {fb, FILE_TAG[31 - 8 * i -: 8]};
			ntracks = ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(1, 4));
			cnt = 16'(ntracks);
			if (kind == 4 && $urandom_range(0, 1) == 1)
				cnt[15:8] = 8'($urandom_range(1, 255));
			fb = {fb, cnt[15:8]};
			fb = {fb, cnt[7:0]};
			for (t = 0; t < ntracks; t++) begin
				tag_at = {tag_at, fb.size()};
				for (i = 0; i < 4; i++)
					fb = {fb, TRACK_TAG[31 - 8 * i -: 8]};
				len = ($urandom_range(0, 7) == 0) ? int'($urandom_range(13, 40))
						: int'($urandom_range(0, 12));
				tlen = 32'(len);
				if (kind == 4 && $urandom_range(0, 2) == 0) begin
					tlen = $urandom | 32'h0100_0000;
					len  = $urandom_range(1, 8);
				end
				for (i = 0; i < 4; i++)
					fb = {fb, tlen[31 - 8 * i -: 8]};
				repeat (len)
					fb = {fb, ($urandom_range(0, 5) == 0) ? CHECKPOINT_BYTE : 8'($urandom)};
			end
			// trailing bytes after the last track
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3)) fb = {fb, 8'($urandom)};
			// damage one magic byte
			if (kind == 2) begin
				pick = tag_at[$urandom_range(0, tag_at.size() - 1)] + int'($urandom_range(0, 3));
				fb[pick] = fb[pick] ^ 8'($urandom_range(1, 255));
			end
			// cut the file short; the next file restarts mid-stream
			if (kind >= 3) begin
				keep = $urandom_range(1, fb.size());
				while (fb.size() > keep)
					void'(fb.pop_back());
			end
		end
		files_sent++;
		for (i = 0; i < fb.size(); i++)
			send_byte(fb[i], i == 0);
	endtask

	task automatic test_good_file();
		// first file straight out of reset, no restart flag
		send_word(FILE_TAG, 4, 1'b0);
		send_word(32'd2, 2, 1'b0);
		send_word(TRACK_TAG, 4, 1'b0);
		send_word(32'd0, 4, 1'b0);
		send_word(TRACK_TAG, 4, 1'b0);
		send_word(32'd3, 4, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(CHECKPOINT_BYTE, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h5A, 1'b0);
		files_sent++;
	endtask

	task automatic test_bad_magic();
		// file magic wrong only in its last byte, then an ignored byte
		send_word({FILE_TAG[31:8], 8'h00}, 4, 1'b1);
		send_byte(8'h4D, 1'b0);
		// track magic wrong in its first byte
		send_word(FILE_TAG, 4, 1'b1);
		send_word(32'd1, 2, 1'b0);
		send_word({8'h00, TRACK_TAG[23:0]}, 4, 1'b0);
		send_byte(CHECKPOINT_BYTE, 1'b0);
		files_sent += 2;
	endtask

	task automatic test_zero_tracks_and_restart();
		send_word(FILE_TAG, 4, 1'b1);
		send_word(32'd0, 2, 1'b0);
		send_byte(8'h4D, 1'b0);
		// largest count and length, abandoned by the next restart
		send_word(FILE_TAG, 4, 1'b1);
		send_word(32'hFFFF, 2, 1'b0);
		send_word(TRACK_TAG, 4, 1'b0);
		send_word(32'hFFFF_FFFF, 4, 1'b0);
		send_byte(CHECKPOINT_BYTE, 1'b0);
		send_byte(8'h7E, 1'b0);
		files_sent += 2;
	endtask

	task automatic test_random_files();
		int target;
		target = parsed_bytes + 450;
		while (parsed_bytes < target)
			send_random_file(1'b0);
	endtask

	task automatic test_back_to_back();
		int target;
		no_idle = 1'b1;
		target = parsed_bytes + 150;
		while (parsed_bytes < target)
			send_random_file(1'b1);
		no_idle = 1'b0;
	endtask

	// Check each result transfer against the oldest prediction; stall the output
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_SHOWN)
					$display("%0t: result with no byte behind it", $time);
			end else begin
				want = pending_results.pop_front();
				if (result_data.event_valid !== want.event_valid
						|| result_data.event_byte !== want.event_byte
						|| result_data.track_number !== want.track_number
						|| result_data.is_checkpoint !== want.is_checkpoint
						|| result_data.last_of_track !== want.last_of_track
						|| result_data.file_done !== want.file_done
						|| result_data.status !== want.status) begin
					fail_count++;
					if (fail_count <= MAX_SHOWN)
						$display({"%0t: expected ev=%b byte=%h trk=%0d ckpt=%b",
								" last=%b done=%b st=%0d,",
								" got ev=%b byte=%h trk=%0d ckpt=%b last=%b done=%b st=%0d"},
								$time, want.event_valid, want.event_byte, want.track_number,
								want.is_checkpoint, want.last_of_track, want.file_done, want.status,
								result_data.event_valid, result_data.event_byte,
								result_data.track_number, result_data.is_checkpoint,
								result_data.last_of_track, result_data.file_done,
								result_data.status);
				end
				events_seen   += result_data.event_valid;
				ckpts_seen    += result_data.is_checkpoint;
				track_ends    += result_data.last_of_track;
				done_results  += result_data.file_done;
				error_results += (result_data.status != STATUS_OK);
			end
		end
		result_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 20);
	end

	// Run the tests in turn, then drain and report
	initial begin
		int waited;
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_good_file();
		test_bad_magic();
		test_zero_tracks_and_restart();
		test_random_files();
		test_back_to_back();
		byte_valid <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		if (pending_results.size() != 0) begin
			$display("%0d results never arrived", pending_results.size());
			fail_count += pending_results.size();
		end
		repeat (10) @(posedge clk);
		$display("Covered %0d files in %0d bytes (%0d parsed), %0d mismatches.",
				files_sent, bytes_sent, parsed_bytes, fail_count);
		$display({"Saw %0d event bytes, %0d checkpoints, %0d track ends,",
				" %0d done and %0d error results."},
				events_seen, ckpts_seen, track_ends, done_results, error_results);
		if (fail_count == 0)
			$display("finger_track_chunk_parser test passed");
		else
			$display("finger_track_chunk_parser test failed");
		$finish;
	end

	// Stop a hung run
	initial begin
		#2_000_000;
		$display("finger_track_chunk_parser test failed");
		$finish;
	end

endmodule

### finger_track_chunk_parser.f
rtl/ftcp_pkg.sv
rtl/ftcp_parser.sv
rtl/finger_track_chunk_parser.sv
tb/sv/tb.sv
